@@ rtl/spc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package spc_pkg;

	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int HUM_W      = 17;

	// register file layout
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMP_CALIB  = 3'd0,
		REG_PRESS_LOW   = 3'd1,
		REG_PRESS_HIGH  = 3'd2,
		REG_PRESS_LAST  = 3'd3,
		REG_HUM_CALIB   = 3'd4,
		REG_HUM_ENABLE  = 3'd5
	} cfg_reg_t;

	// s1..s11 front end, s12..s75 divider, s76..s80 pressure back end
	localparam int NUM_STAGES = 80;
	localparam int DIV_STEPS  = 64;

	localparam logic [31:0] T_ROUND     = 32'd128;
	localparam logic [33:0] P_OFFSET    = 34'd128000;
	localparam logic [20:0] P_FULL      = 21'd1048576;
	localparam logic [11:0] P_SCALE     = 12'd3125;
	localparam logic [63:0] P_BIAS47    = 64'h0000_8000_0000_0000;
	localparam logic [31:0] H_OFFSET    = 32'd76800;
	localparam logic [31:0] H_ROUND14   = 32'd16384;
	localparam logic [31:0] H_BIAS15    = 32'd32768;
	localparam logic [31:0] H_BIAS21    = 32'd2097152;
	localparam logic [31:0] H_ROUND13   = 32'd8192;
	localparam logic [31:0] H_MAX       = 32'd419430400;

	// results that ride alongside the divider
	typedef struct packed {
		logic [31:0]      temp;
		logic [31:0]      tfine;
		logic [HUM_W-1:0] hum;
		logic             invalid;
		logic             neg;
	} side_t;

	typedef struct packed {
		logic [31:0] temp;
		logic [31:0] tfine;
	} tres_t;

endpackage

`default_nettype wire

@@ rtl/sensor_raw_compensation.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Handshake                 | Payload
// ---------+---------------------------+-----------------------------------------
// input    | in_valid / in_ready       | raw_pressure, raw_temperature,
//          |                           | raw_humidity
// output   | out_valid / out_ready     | temperature_centi, fine_temperature,
//          |                           | pressure_q24_8, pressure_invalid,
//          |                           | humidity_q22_10
// config   | cfg_en (no wait)          | cfg_index, cfg_data
//
// One transfer per cycle unless the output stalls; the pipeline is the 64
// stage restoring divider for pressure plus 11 front and 5 back end stages.
// arst_n clears the calibration registers and all stage valid bits.
// The whole pipeline holds while the output register is full and out_ready
// is low; in_ready follows that same advance signal.

module sensor_raw_compensation (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_en,
	input  wire logic [spc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [spc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [19:0]                   raw_pressure,
	input  wire logic [19:0]                   raw_temperature,
	input  wire logic [15:0]                   raw_humidity,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [31:0]                 temperature_centi,
	output logic signed [31:0]                 fine_temperature,
	output logic [31:0]                        pressure_q24_8,
	output logic                               pressure_invalid,
	output logic [spc_pkg::HUM_W-1:0]          humidity_q22_10
);

	localparam int NS = spc_pkg::NUM_STAGES;
	localparam int ND = spc_pkg::DIV_STEPS;

	// configuration
	logic [47:0] temp_calib_q;
	logic [63:0] press_low_q;
	logic [63:0] press_high_q;
	logic [15:0] press_last_q;
	logic [63:0] hum_calib_q;
	logic        hum_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_calib_q <= '0;
			press_low_q  <= '0;
			press_high_q <= '0;
			press_last_q <= '0;
			hum_calib_q  <= '0;
			hum_en_q     <= 1'b0;
		end else if (cfg_en) begin
			case (cfg_index)
				spc_pkg::REG_TEMP_CALIB: temp_calib_q <= cfg_data[47:0];
				spc_pkg::REG_PRESS_LOW:  press_low_q  <= cfg_data;
				spc_pkg::REG_PRESS_HIGH: press_high_q <= cfg_data;
				spc_pkg::REG_PRESS_LAST: press_last_q <= cfg_data[15:0];
				spc_pkg::REG_HUM_CALIB:  hum_calib_q  <= cfg_data;
				spc_pkg::REG_HUM_ENABLE: hum_en_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic [15:0]        t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
	logic [7:0]         h1, h3;
	logic signed [11:0] h4, h5;
	logic signed [7:0]  h6;

	assign t1 = temp_calib_q[15:0];
	assign t2 = temp_calib_q[31:16];
	assign t3 = temp_calib_q[47:32];
	assign p1 = press_low_q[15:0];
	assign p2 = press_low_q[31:16];
	assign p3 = press_low_q[47:32];
	assign p4 = press_low_q[63:48];
	assign p5 = press_high_q[15:0];
	assign p6 = press_high_q[31:16];
	assign p7 = press_high_q[47:32];
	assign p8 = press_high_q[63:48];
	assign p9 = press_last_q;
	assign h1 = hum_calib_q[7:0];
	assign h2 = hum_calib_q[23:8];
	assign h3 = hum_calib_q[31:24];
	assign h4 = hum_calib_q[43:32];
	assign h5 = hum_calib_q[55:44];
	assign h6 = hum_calib_q[63:56];

	// flow control
	logic [NS-1:0] vld_q;
	logic          adv;

	assign adv       = !vld_q[NS-1] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NS-2:0], in_valid};
		end
	end

	// s1..s4: temperature
	logic [31:0] x1, dt;
	logic [31:0] tx_s1, dd_s1;
	logic [19:0] rp_s1, rp_s2, rp_s3, rp_s4, rp_s5, rp_s6, rp_s7;
	logic [15:0] rh_s1, rh_s2, rh_s3, rh_s4;
	logic [31:0] txa, dda, ta_s2, tb_s2, tba, tfine_s3;
	logic [31:0] t5, tempv;

	assign x1  = 32'(raw_temperature[19:3]) - 32'({t1, 1'b0});
	assign dt  = 32'(raw_temperature[19:4]) - 32'(t1);
	assign txa = $signed(tx_s1) >>> 11;
	assign dda = $signed(dd_s1) >>> 12;
	assign tba = $signed(tb_s2) >>> 14;
	assign t5  = tfine_s3 * 32'd5 + spc_pkg::T_ROUND;
	assign tempv = $signed(t5) >>> 8;

	always_ff @(posedge clk) begin
		if (adv) begin
			tx_s1    <= $signed(x1) * t2;
			dd_s1    <= dt * dt;
			rp_s1    <= raw_pressure;
			rh_s1    <= raw_humidity;
			ta_s2    <= txa;
			tb_s2    <= $signed(dda) * t3;
			rp_s2    <= rp_s1;
			rh_s2    <= rh_s1;
			tfine_s3 <= ta_s2 + tba;
			rp_s3    <= rp_s2;
			rh_s3    <= rh_s2;
		end
	end

	// s4..s11: pressure divisor and dividend
	logic signed [33:0] pv1;
	logic [63:0]        vsq_s4, m6_s5, m3_s5, m3a, v2_s6, w_s6, v2_s7, wp1_s7;
	logic signed [49:0] v1p5_s4, v1p2_s4, v1p5_s5, v1p2_s5;
	logic [63:0]        den, num, den_s8, num_s8, den_s9, num_s9, den_s10, num_s10;
	logic [20:0]        pr;

	assign pv1 = {{2{tfine_s3[31]}}, tfine_s3} - spc_pkg::P_OFFSET;
	assign m3a = $signed(m3_s5) >>> 8;
	assign den = $signed(wp1_s7) >>> 33;
	assign pr  = spc_pkg::P_FULL - {1'b0, rp_s7};
	assign num = ((64'(pr) << 31) - v2_s7) * spc_pkg::P_SCALE;

	always_ff @(posedge clk) begin
		if (adv) begin
			vsq_s4  <= pv1 * pv1;
			v1p5_s4 <= pv1 * p5;
			v1p2_s4 <= pv1 * p2;
			rp_s4   <= rp_s3;
			m6_s5   <= $signed(vsq_s4) * p6;
			m3_s5   <= $signed(vsq_s4) * p3;
			v1p5_s5 <= v1p5_s4;
			v1p2_s5 <= v1p2_s4;
			rp_s5   <= rp_s4;
			v2_s6   <= m6_s5 + (64'(v1p5_s5) << 17) + (64'(p4) << 35);
			w_s6    <= m3a + (64'(v1p2_s5) << 12);
			rp_s6   <= rp_s5;
			wp1_s7  <= (w_s6 + spc_pkg::P_BIAS47) * p1;
			v2_s7   <= v2_s6;
			rp_s7   <= rp_s6;
			den_s8  <= den;
			num_s8  <= num;
			den_s9  <= den_s8;
			num_s9  <= num_s8;
			den_s10 <= den_s9;
			num_s10 <= num_s9;
		end
	end

	// s4..s11: humidity
	logic [31:0] hx, lsum, lsh, xh6a, xh3a, r0a, ra, rsum, rb, sv, hsa, hy, hyc;
	logic [31:0] h5x_s4, xh6_s4, xh3_s4;
	logic [31:0] l_s5, ha_s5, hb_s5, l_s6, r0_s6, l_s7, r1_s7;
	logic [31:0] hx_s8, hx_s9, ss_s9, ssa, hx_s10, hs_s10;
	logic [spc_pkg::HUM_W-1:0] humv;

	assign hx   = tfine_s3 - spc_pkg::H_OFFSET;
	assign lsum = {2'b00, rh_s4, 14'd0} - (32'(h4) << 20) - h5x_s4 + spc_pkg::H_ROUND14;
	assign lsh  = $signed(lsum) >>> 15;
	assign xh6a = $signed(xh6_s4) >>> 10;
	assign xh3a = $signed(xh3_s4) >>> 11;
	assign r0a  = $signed(r0_s6) >>> 10;
	assign ra   = r0a + spc_pkg::H_BIAS21;
	assign rsum = r1_s7 + spc_pkg::H_ROUND13;
	assign rb   = $signed(rsum) >>> 14;
	assign sv   = $signed(hx_s8) >>> 15;
	assign ssa  = $signed(ss_s9) >>> 7;
	assign hsa  = $signed(hs_s10) >>> 4;
	assign hy   = hx_s10 - hsa;

	always_comb begin
		if (hy[31]) begin
			hyc = '0;
		end else if (hy > spc_pkg::H_MAX) begin
			hyc = spc_pkg::H_MAX;
		end else begin
			hyc = hy;
		end
		humv = hum_en_q ? hyc[28:12] : '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			h5x_s4 <= $signed(hx) * h5;
			xh6_s4 <= $signed(hx) * h6;
			xh3_s4 <= hx * h3;
			rh_s4  <= rh_s3;
			l_s5   <= lsh;
			ha_s5  <= xh6a;
			hb_s5  <= xh3a + spc_pkg::H_BIAS15;
			l_s6   <= l_s5;
			r0_s6  <= ha_s5 * hb_s5;
			l_s7   <= l_s6;
			r1_s7  <= $signed(ra) * h2;
			hx_s8  <= l_s7 * rb;
			hx_s9  <= hx_s8;
			ss_s9  <= sv * sv;
			hx_s10 <= hx_s9;
			hs_s10 <= ssa * h1;
		end
	end

	// temperature results carried to the divider entry
	spc_pkg::tres_t tt_s4, tt_s5, tt_s6, tt_s7, tt_s8, tt_s9, tt_s10;

	always_ff @(posedge clk) begin
		if (adv) begin
			tt_s4  <= '{temp: tempv, tfine: tfine_s3};
			tt_s5  <= tt_s4;
			tt_s6  <= tt_s5;
			tt_s7  <= tt_s6;
			tt_s8  <= tt_s7;
			tt_s9  <= tt_s8;
			tt_s10 <= tt_s9;
		end
	end

	// s11: magnitudes; s12..s75: one quotient bit per stage
	logic [127:0]   rq_sd [ND+1];
	logic [63:0]    md_sd [ND+1];
	spc_pkg::side_t sd_sd [ND+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			rq_sd[0] <= {64'd0, num_s10[63] ? 64'd0 - num_s10 : num_s10};
			md_sd[0] <= den_s10[63] ? 64'd0 - den_s10 : den_s10;
			sd_sd[0] <= '{temp: tt_s10.temp, tfine: tt_s10.tfine, hum: humv,
				invalid: den_s10 == 64'd0, neg: num_s10[63] ^ den_s10[63]};
		end
	end

	for (genvar k = 0; k < ND; k++) begin : g_div
		logic [128:0] sh;
		logic [64:0]  hi, dif;
		logic         qb;

		assign sh  = {rq_sd[k], 1'b0};
		assign hi  = sh[128:64];
		assign dif = hi - {1'b0, md_sd[k]};
		assign qb  = !dif[64];

		always_ff @(posedge clk) begin
			if (adv) begin
				rq_sd[k+1] <= {qb ? dif[63:0] : hi[63:0], sh[63:1], qb};
				md_sd[k+1] <= md_sd[k];
				sd_sd[k+1] <= sd_sd[k];
			end
		end
	end

	// s76..s80: pressure back end
	logic [63:0]    q, ps, p_s76, p_s77, ps_s77, pa_s77, p8p_s77, p8a;
	logic [63:0]    p_s78, ll_s78, pb_s78, prod, pva, p_s79, pv1_s79, pb_s79;
	logic [63:0]    psum, psa, press;
	logic [31:0]    lh_s78, hl_s78;
	spc_pkg::side_t sd_s76, sd_s77, sd_s78, sd_s79;

	assign q     = rq_sd[ND][63:0];
	assign ps    = $signed(p_s76) >>> 13;
	assign p8a   = $signed(p8p_s77) >>> 19;
	assign prod  = ll_s78 + {lh_s78 + hl_s78, 32'd0};
	assign pva   = $signed(prod) >>> 25;
	assign psum  = p_s79 + pv1_s79 + pb_s79;
	assign psa   = $signed(psum) >>> 8;
	assign press = psa + (64'(p7) << 4);

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s76   <= sd_sd[ND].neg ? 64'd0 - q : q;
			sd_s76  <= sd_sd[ND];
			p_s77   <= p_s76;
			ps_s77  <= ps;
			pa_s77  <= $signed(ps) * p9;
			p8p_s77 <= $signed(p_s76) * p8;
			sd_s77  <= sd_s76;
			// low 64 bits of pa * ps from three 32 x 32 partial products
			ll_s78  <= pa_s77[31:0] * ps_s77[31:0];
			lh_s78  <= pa_s77[31:0] * ps_s77[63:32];
			hl_s78  <= pa_s77[63:32] * ps_s77[31:0];
			pb_s78  <= p8a;
			p_s78   <= p_s77;
			sd_s78  <= sd_s77;
			pv1_s79 <= pva;
			pb_s79  <= pb_s78;
			p_s79   <= p_s78;
			sd_s79  <= sd_s78;
			temperature_centi <= sd_s79.temp;
			fine_temperature  <= sd_s79.tfine;
			pressure_q24_8    <= sd_s79.invalid ? 32'd0 : press[31:0];
			pressure_invalid  <= sd_s79.invalid;
			humidity_q22_10   <= sd_s79.hum;
		end
	end

endmodule

`default_nettype wire

@@ tb/spc_checker.sv @@
`timescale 1ns / 1ps

module spc_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_en,
	input  wire logic [spc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [spc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	input  wire logic                           in_ready,
	input  wire logic [19:0]                    raw_pressure,
	input  wire logic [19:0]                    raw_temperature,
	input  wire logic [15:0]                    raw_humidity,
	input  wire logic                           out_valid,
	input  wire logic                           out_ready,
	input  wire logic [31:0]                    temperature_centi,
	input  wire logic [31:0]                    fine_temperature,
	input  wire logic [31:0]                    pressure_q24_8,
	input  wire logic                           pressure_invalid,
	input  wire logic [spc_pkg::HUM_W-1:0]      humidity_q22_10,
	output int                                  fail_count,
	output int                                  pending
);

	typedef struct packed {
		logic [31:0]               temp;
		logic [31:0]               tfine;
		logic [31:0]               press;
		logic                      invalid;
		logic [spc_pkg::HUM_W-1:0] hum;
	} reading_t;

	// shadow calibration registers
	logic [47:0] temp_cal;
	logic [63:0] press_lo, press_hi, hum_cal;
	logic [15:0] press_p9;
	logic        hum_en;

	reading_t readings_due[$];

	function automatic logic [31:0] sra32(logic [31:0] v, int s);
		return v[31] ? ~((~v) >> s) : (v >> s);
	endfunction

	function automatic logic [63:0] sra64(logic [63:0] v, int s);
		return v[63] ? ~((~v) >> s) : (v >> s);
	endfunction

	// truncating signed divide on raw bit patterns
	function automatic logic [63:0] sdiv64(logic [63:0] n, logic [63:0] d);
		logic [63:0] mn, md, q;
		mn = n[63] ? -n : n;
		md = d[63] ? -d : d;
		q  = mn / md;
		return (n[63] != d[63]) ? -q : q;
	endfunction

	function automatic logic [63:0] sx16(logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic reading_t compensate(logic [19:0] rp, logic [19:0] rt, logic [15:0] rh);
		reading_t r;
		logic [31:0] t1, t2, t3, a, d, b, tf;
		logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, ps;
		logic [31:0] h1, h2, h3, h4, h5, h6, x, l, q, s;
		t1 = {16'd0, temp_cal[15:0]};
		t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
		t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};
		a  = sra32((({12'd0, rt} >> 3) - (t1 << 1)) * t2, 11);
		d  = ({12'd0, rt} >> 4) - t1;
		b  = sra32(sra32(d * d, 12) * t3, 14);
		tf = a + b;
		r.tfine = tf;
		r.temp  = sra32(tf * 32'd5 + spc_pkg::T_ROUND, 8);

		p1 = {48'd0, press_lo[15:0]};
		p2 = sx16(press_lo[31:16]);
		p3 = sx16(press_lo[47:32]);
		p4 = sx16(press_lo[63:48]);
		p5 = sx16(press_hi[15:0]);
		p6 = sx16(press_hi[31:16]);
		p7 = sx16(press_hi[47:32]);
		p8 = sx16(press_hi[63:48]);
		p9 = sx16(press_p9);
		v1 = {{32{tf[31]}}, tf} - 64'd128000;
		v2 = v1 * v1 * p6;
		v2 = v2 + ((v1 * p5) << 17);
		v2 = v2 + (p4 << 35);
		v1 = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
		v1 = sra64((spc_pkg::P_BIAS47 + v1) * p1, 33);
		r.invalid = (v1 == 64'd0);
		r.press = 32'd0;
		if (!r.invalid) begin
			p  = 64'd1048576 - {44'd0, rp};
			p  = sdiv64(((p << 31) - v2) * 64'd3125, v1);
			ps = sra64(p, 13);
			v1 = sra64(p9 * ps * ps, 25);
			v2 = sra64(p8 * p, 19);
			r.press = 32'(sra64(p + v1 + v2, 8) + (p7 << 4));
		end

		r.hum = '0;
		if (hum_en) begin
			h1 = {24'd0, hum_cal[7:0]};
			h2 = {{16{hum_cal[23]}}, hum_cal[23:8]};
			h3 = {24'd0, hum_cal[31:24]};
			h4 = {{20{hum_cal[43]}}, hum_cal[43:32]};
			h5 = {{20{hum_cal[55]}}, hum_cal[55:44]};
			h6 = {{24{hum_cal[63]}}, hum_cal[63:56]};
			x = tf - spc_pkg::H_OFFSET;
			l = sra32(({16'd0, rh} << 14) - (h4 << 20) - h5 * x + spc_pkg::H_ROUND14, 15);
			q = sra32(x * h6, 10) * (sra32(x * h3, 11) + spc_pkg::H_BIAS15);
			q = sra32(q, 10) + spc_pkg::H_BIAS21;
			q = sra32(q * h2 + spc_pkg::H_ROUND13, 14);
			x = l * q;
			s = sra32(x, 15);
			x = x - sra32(sra32(s * s, 7) * h1, 4);
			if (x[31])
				x = 32'd0;
			else if (x > spc_pkg::H_MAX)
				x = spc_pkg::H_MAX;
			r.hum = spc_pkg::HUM_W'(x >> 12);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal <= '0;
			press_lo <= '0;
			press_hi <= '0;
			press_p9 <= '0;
			hum_cal  <= '0;
			hum_en   <= 1'b0;
		end else if (cfg_en) begin
			case (cfg_index)
				spc_pkg::REG_TEMP_CALIB: temp_cal <= cfg_data[47:0];
				spc_pkg::REG_PRESS_LOW:  press_lo <= cfg_data;
				spc_pkg::REG_PRESS_HIGH: press_hi <= cfg_data;
				spc_pkg::REG_PRESS_LAST: press_p9 <= cfg_data[15:0];
				spc_pkg::REG_HUM_CALIB:  hum_cal  <= cfg_data;
				spc_pkg::REG_HUM_ENABLE: hum_en   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	initial fail_count = 0;
	initial pending = 0;

	always @(posedge clk) begin
		reading_t want;
		if (arst_n && in_valid && in_ready)
			readings_due.push_back(compensate(raw_pressure, raw_temperature, raw_humidity));
		if (arst_n && out_valid && out_ready) begin
			if (readings_due.size() == 0) begin
				$error("result transfer with no reading outstanding");
				fail_count++;
			end else begin
				want = readings_due.pop_front();
				if (temperature_centi !== want.temp) begin
					$error("temperature_centi: expected %0d, got %0d",
						$signed(want.temp), $signed(temperature_centi));
					fail_count++;
				end
				if (fine_temperature !== want.tfine) begin
					$error("fine_temperature: expected %0d, got %0d",
						$signed(want.tfine), $signed(fine_temperature));
					fail_count++;
				end
				if (pressure_q24_8 !== want.press) begin
					$error("pressure_q24_8: expected %0h, got %0h", want.press, pressure_q24_8);
					fail_count++;
				end
				if (pressure_invalid !== want.invalid) begin
					$error("pressure_invalid: expected %0b, got %0b",
						want.invalid, pressure_invalid);
					fail_count++;
				end
				if (humidity_q22_10 !== want.hum) begin
					$error("humidity_q22_10: expected %0d, got %0d", want.hum, humidity_q22_10);
					fail_count++;
				end
			end
		end
		pending <= readings_due.size();
	end

endmodule

@@ tb/sensor_raw_compensation_tb.sv @@
`timescale 1ns / 1ps

module sensor_raw_compensation_tb;

	localparam logic [spc_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd6;
	localparam int STALL_LIMIT = 6000;

	// typical factory calibration
	localparam logic [47:0] CAL_T  = {16'hFC18, 16'd26435, 16'd27504};
	localparam logic [63:0] CAL_PL = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
	localparam logic [63:0] CAL_PH = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
	localparam logic [15:0] CAL_P9 = 16'd6000;
	localparam logic [63:0] CAL_H  = {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75};

	logic clk, arst_n;
	logic cfg_en;
	logic [spc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [spc_pkg::CFG_DATA_W-1:0] cfg_data;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [19:0] raw_pressure, raw_temperature;
	logic [15:0] raw_humidity;
	logic signed [31:0] temperature_centi, fine_temperature;
	logic [31:0] pressure_q24_8;
	logic pressure_invalid;
	logic [spc_pkg::HUM_W-1:0] humidity_q22_10;
	int fail_count, pending;
	int idle_cycles;
	bit sink_steady;

	sensor_raw_compensation uut (.*);

	spc_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(20, 150);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic write_reg(logic [spc_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
		cfg_en    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_calib(logic [47:0] t, logic [63:0] pl, logic [63:0] ph,
			logic [15:0] p9, logic [63:0] h, logic hen);
		write_reg(spc_pkg::REG_TEMP_CALIB, {16'hA5A5, t});
		write_reg(spc_pkg::REG_PRESS_LOW, pl);
		write_reg(spc_pkg::REG_PRESS_HIGH, ph);
		write_reg(spc_pkg::REG_PRESS_LAST, {48'hFFFF_0000_FFFF, p9});
		write_reg(spc_pkg::REG_HUM_CALIB, h);
		write_reg(spc_pkg::REG_HUM_ENABLE, {63'h5A5A_5A5A_5A5A_5A5A, hen});
	endtask

	// drop valid and let the pipeline drain before touching calibration
	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (spc_pkg::NUM_STAGES + 10) @(negedge clk);
	endtask

	// valid stays up between back to back transfers
	task automatic send_reading(logic [19:0] p, logic [19:0] t, logic [15:0] h);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid        <= 1'b1;
		raw_pressure    <= p;
		raw_temperature <= t;
		raw_humidity    <= h;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_random(int n, bit plausible);
		repeat (n) begin
			if (plausible && $urandom_range(0, 9) < 7)
				send_reading(20'($urandom_range(250000, 500000)),
					20'($urandom_range(400000, 600000)),
					16'($urandom_range(15000, 45000)));
			else
				send_reading(20'($urandom), 20'($urandom), 16'($urandom));
		end
	endtask

	function automatic logic [15:0] nudge(logic [15:0] v);
		return v + 16'($urandom_range(0, 64)) - 16'd32;
	endfunction

	// result side: random back-pressure, with stretches held ready
	initial begin
		int g;
		out_ready = 1'b0;
		sink_steady = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 199) == 0) sink_steady = ~sink_steady;
			if (sink_steady) begin
				out_ready <= 1'b1;
			end else if ($urandom_range(0, 2) == 0) begin
				g = gap_len();
				if (g > 0) begin
					out_ready <= 1'b0;
					repeat (g) @(negedge clk);
				end
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		logic [47:0] t;
		logic [63:0] pl, ph, h;
		idle_cycles     = 0;
		arst_n          = 1'b0;
		cfg_en          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		in_valid        = 1'b0;
		raw_pressure    = '0;
		raw_temperature = '0;
		raw_humidity    = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset calibration: pressure divisor is zero, humidity off
		send_reading(20'd0, 20'd0, 16'd0);
		send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		settle();

		load_calib(CAL_T, CAL_PL, CAL_PH, CAL_P9, CAL_H, 1'b1);
		write_reg(CFG_IDX_SPARE, rand64());
		send_reading(20'd415148, 20'd519888, 16'd30000);
		send_reading(20'd0, 20'd0, 16'd0);
		send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		send_reading(20'd0, 20'hFFFFF, 16'd0);
		send_reading(20'hFFFFF, 20'd0, 16'hFFFF);
		send_reading(20'h80000, 20'h80000, 16'h8000);
		send_reading(20'd415148, 20'd519888, 16'd65535);
		send_reading(20'd415148, 20'd300000, 16'd0);
		settle();

		load_calib(CAL_T, CAL_PL, CAL_PH, CAL_P9, CAL_H, 1'b0);
		send_reading(20'd415148, 20'd519888, 16'd30000);
		send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		settle();

		load_calib('1, '1, '1, '1, '1, 1'b1);
		send_reading(20'd0, 20'd0, 16'd0);
		send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		send_reading(20'h12345, 20'h6789A, 16'hBCDE);
		settle();

		load_calib({3{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, 16'h8000,
			{8'h80, 12'h800, 12'h800, 8'hFF, 16'h8000, 8'hFF}, 1'b1);
		send_reading(20'd0, 20'd0, 16'd0);
		send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		send_reading(20'd415148, 20'd519888, 16'd30000);
		settle();

		load_calib({3{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, 16'h7FFF,
			{8'h7F, 12'h7FF, 12'h7FF, 8'hFF, 16'h7FFF, 8'hFF}, 1'b1);
		send_reading(20'd0, 20'd0, 16'd0);
		send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		settle();

		// random phases: mostly near-factory calibration, some arbitrary
		for (int ph_i = 0; ph_i < 14; ph_i++) begin
			if (ph_i % 4 == 3) begin
				t = 48'(rand64()); pl = rand64(); ph = rand64(); h = rand64();
				load_calib(t, pl, ph, 16'($urandom), h, 1'($urandom));
				send_random(100, 1'b0);
			end else begin
				t  = {nudge(CAL_T[47:32]), nudge(CAL_T[31:16]), nudge(CAL_T[15:0])};
				pl = {nudge(CAL_PL[63:48]), nudge(CAL_PL[47:32]), nudge(CAL_PL[31:16]),
					nudge(CAL_PL[15:0])};
				ph = {nudge(CAL_PH[63:48]), nudge(CAL_PH[47:32]), nudge(CAL_PH[31:16]),
					nudge(CAL_PH[15:0])};
				h  = {CAL_H[63:56] + 8'($urandom_range(0, 8)), CAL_H[55:8],
					CAL_H[7:0] + 8'($urandom_range(0, 8))};
				load_calib(t, pl, ph, nudge(CAL_P9), h, ($urandom_range(0, 4) != 0));
				send_random(100, 1'b1);
			end
			settle();
		end

		while (pending != 0) @(posedge clk);
		repeat (spc_pkg::NUM_STAGES + 20) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ sensor_raw_compensation.f @@
rtl/spc_pkg.sv
rtl/sensor_raw_compensation.sv
tb/spc_checker.sv
tb/sensor_raw_compensation_tb.sv
